>>> hw/rtl/rme_pkg.sv
// shared types, codes and constants for the redundancy master election block
package rme_pkg;

    // fixed field and state widths
    localparam int CNT_W  = 20;
    localparam int CTR_W  = 64;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // default timer rate, ticks per second
    localparam int TICKS_PER_SECOND_DEF = 1000;

    // timer load factors
    localparam int DOWN_MULT  = 3;
    localparam int SKEW_SHIFT = 8;

    // advertisement checks
    localparam logic [3:0] RX_VERSION = 4'd2;
    localparam logic [7:0] MCAST_TTL  = 8'd255;

    // operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_USER = 2'd2;
    // unused code, changes nothing
    localparam logic [1:0] OP_NONE = 2'd3;

    // role codes
    localparam logic [1:0] ROLE_INIT   = 2'd0;
    localparam logic [1:0] ROLE_BACKUP = 2'd1;
    localparam logic [1:0] ROLE_MASTER = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_VHID_MISS   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_TTL     = 3'd4;
    localparam logic [2:0] ST_BAD_AUTH    = 3'd5;

    // register indexes
    localparam logic [2:0] REG_ACCEPT_ENABLE   = 3'd0;
    localparam logic [2:0] REG_PREEMPT_ENABLE  = 3'd1;
    localparam logic [2:0] REG_GROUP_ID        = 3'd2;
    localparam logic [2:0] REG_BASE_INTERVAL   = 3'd3;
    localparam logic [2:0] REG_SKEW            = 3'd4;
    localparam logic [2:0] REG_GROUP_MULTICAST = 3'd5;
    localparam logic [2:0] REG_HAS_ADDRESSES   = 3'd6;

    // input word
    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       rx_group_id;
        logic [3:0]       rx_version;
        logic [7:0]       rx_base;
        logic [7:0]       rx_ttl;
        logic             rx_auth_ok;
        logic [CTR_W-1:0] rx_counter;
        logic [1:0]       requested_state;
        logic [CTR_W-1:0] random_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       current_state;
        logic             send_advert;
        logic [CTR_W-1:0] advert_counter;
        logic [7:0]       advert_base;
        logic [7:0]       advert_skew;
    } t_out_word;

    // configuration handed from the register file to the core
    typedef struct packed {
        logic       accept_enable;
        logic       preempt_enable;
        logic [7:0] group_id;
        logic [7:0] base_interval;
        logic [7:0] skew;
        logic       group_multicast;
        logic       has_addresses;
    } t_cfg;

endpackage

>>> hw/rtl/rme_stream_if.sv
// valid/ready stream interface carrying one word of type T
interface rme_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rme_apb_regs.sv
// apb configuration registers of the election block
module rme_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]  paddr,
    input  logic [rme_pkg::DATA_W-1:0]  pwdata,
    output logic [rme_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output rme_pkg::t_cfg               o_cfg
);
    rme_pkg::t_cfg r_cfg;
    logic [2:0]    w_index;
    logic          w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[rme_pkg::ADDR_W-1:2];
    assign w_write = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accept_enable   <= 1'b1;
            r_cfg.preempt_enable  <= 1'b0;
            r_cfg.group_id        <= 8'd1;
            r_cfg.base_interval   <= 8'd1;
            r_cfg.skew            <= 8'd0;
            r_cfg.group_multicast <= 1'b1;
            r_cfg.has_addresses   <= 1'b0;
        end else if (w_write) begin
            case (w_index)
                rme_pkg::REG_ACCEPT_ENABLE:   r_cfg.accept_enable   <= pwdata[0];
                rme_pkg::REG_PREEMPT_ENABLE:  r_cfg.preempt_enable  <= pwdata[0];
                rme_pkg::REG_GROUP_ID:        r_cfg.group_id        <= pwdata[7:0];
                rme_pkg::REG_BASE_INTERVAL:   r_cfg.base_interval   <= pwdata[7:0];
                rme_pkg::REG_SKEW:            r_cfg.skew            <= pwdata[7:0];
                rme_pkg::REG_GROUP_MULTICAST: r_cfg.group_multicast <= pwdata[0];
                rme_pkg::REG_HAS_ADDRESSES:   r_cfg.has_addresses   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_index)
            rme_pkg::REG_ACCEPT_ENABLE:   prdata[0]   = r_cfg.accept_enable;
            rme_pkg::REG_PREEMPT_ENABLE:  prdata[0]   = r_cfg.preempt_enable;
            rme_pkg::REG_GROUP_ID:        prdata[7:0] = r_cfg.group_id;
            rme_pkg::REG_BASE_INTERVAL:   prdata[7:0] = r_cfg.base_interval;
            rme_pkg::REG_SKEW:            prdata[7:0] = r_cfg.skew;
            rme_pkg::REG_GROUP_MULTICAST: prdata[0]   = r_cfg.group_multicast;
            rme_pkg::REG_HAS_ADDRESSES:   prdata[0]   = r_cfg.has_addresses;
            default:                      prdata      = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

>>> hw/rtl/rme_core.sv
// election core: input register, role/timer/counter update, result register
module rme_core #(
    parameter int TICKS_PER_SECOND = rme_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rme_pkg::t_cfg i_cfg,
    rme_stream_if.sink    i_in,
    rme_stream_if.source  o_out
);
    localparam int CW = rme_pkg::CNT_W;
    localparam logic [31:0] TpsK  = 32'(TICKS_PER_SECOND);
    localparam logic [31:0] DownK = 32'(rme_pkg::DOWN_MULT * TICKS_PER_SECOND);

    // pipeline registers
    logic               r_in_valid;
    rme_pkg::t_in_word  r_in;
    logic               r_out_valid;
    rme_pkg::t_out_word r_out;
    logic               w_advance;

    // election state
    logic [1:0]                 r_role,      n_role;
    logic [CW-1:0]              r_countdown, n_countdown;
    logic                       r_running,   n_running;
    logic [rme_pkg::CTR_W-1:0]  r_replay,    n_replay;
    logic                       r_unseeded,  n_unseeded;
    rme_pkg::t_out_word         n_out;

    // timer reload values
    logic [31:0]   w_base_prod, w_skew_prod, w_own_prod, w_rx_prod;
    logic [CW-1:0] w_master_load, w_own_down, w_rx_down;
    logic [9:0]    w_rx_base3;

    // decision flags
    logic       w_adv, w_ld_own, w_ld_rx;
    logic [2:0] w_status;
    logic [CW-1:0] w_dec;

    // handshake: stage 1 moves on when the result slot is free or being taken
    assign w_advance  = ~r_out_valid | o_out.ready;
    assign i_in.ready = ~r_in_valid | w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // timer reload arithmetic
    assign w_base_prod   = 32'(i_cfg.base_interval) * TpsK;
    assign w_skew_prod   = 32'(i_cfg.skew) * TpsK;
    assign w_master_load = CW'(w_base_prod + (w_skew_prod >> rme_pkg::SKEW_SHIFT));
    assign w_own_prod    = 32'(i_cfg.base_interval) * DownK;
    assign w_own_down    = w_own_prod[CW-1:0];
    assign w_rx_prod     = 32'(r_in.rx_base) * DownK;
    assign w_rx_down     = w_rx_prod[CW-1:0];
    assign w_rx_base3    = 10'(r_in.rx_base) * 10'(rme_pkg::DOWN_MULT);
    assign w_dec         = (r_countdown != '0) ? r_countdown - CW'(1) : r_countdown;

    // advertisement checks in priority order
    always_comb begin
        if (!i_cfg.accept_enable) begin
            w_status = rme_pkg::ST_NOT_ACCEPT;
        end else if (r_in.rx_group_id != i_cfg.group_id) begin
            w_status = rme_pkg::ST_VHID_MISS;
        end else if (r_in.rx_version != rme_pkg::RX_VERSION) begin
            w_status = rme_pkg::ST_BAD_VERSION;
        end else if (i_cfg.group_multicast && r_in.rx_ttl != rme_pkg::MCAST_TTL) begin
            w_status = rme_pkg::ST_BAD_TTL;
        end else if (!r_in.rx_auth_ok) begin
            w_status = rme_pkg::ST_BAD_AUTH;
        end else begin
            w_status = rme_pkg::ST_OK;
        end
    end

    // next state and result word
    always_comb begin
        n_role      = r_role;
        n_countdown = r_countdown;
        n_running   = r_running;
        n_replay    = r_replay;
        n_unseeded  = r_unseeded;
        w_adv       = 1'b0;
        w_ld_own    = 1'b0;
        w_ld_rx     = 1'b0;
        n_out       = '0;

        case (r_in.operation)
            rme_pkg::OP_TICK: begin
                if (r_running) begin
                    n_countdown = w_dec;
                    if (w_dec == '0) begin
                        n_running = 1'b0;
                        if (r_role == rme_pkg::ROLE_MASTER ||
                            r_role == rme_pkg::ROLE_BACKUP) begin
                            n_role = rme_pkg::ROLE_MASTER;
                            w_adv  = 1'b1;
                        end
                    end
                end
            end
            rme_pkg::OP_RX: begin
                n_out.status = w_status;
                if (w_status == rme_pkg::ST_OK) begin
                    n_replay   = r_in.rx_counter;
                    n_unseeded = 1'b0;
                    if (r_role == rme_pkg::ROLE_MASTER) begin
                        if (r_in.rx_base <= i_cfg.base_interval) begin
                            n_role   = rme_pkg::ROLE_BACKUP;
                            w_ld_own = 1'b1;
                        end
                    end else if (r_role == rme_pkg::ROLE_BACKUP) begin
                        if ((i_cfg.preempt_enable && r_in.rx_base > i_cfg.base_interval) ||
                            w_rx_base3 <= 10'(i_cfg.base_interval)) begin
                            n_role = rme_pkg::ROLE_MASTER;
                            w_adv  = 1'b1;
                        end else begin
                            w_ld_rx = 1'b1;
                        end
                    end
                end
            end
            rme_pkg::OP_USER: begin
                if (r_in.requested_state != r_role) begin
                    if (r_in.requested_state == rme_pkg::ROLE_BACKUP) begin
                        n_role   = rme_pkg::ROLE_BACKUP;
                        w_ld_own = 1'b1;
                    end else if (r_in.requested_state == rme_pkg::ROLE_MASTER) begin
                        n_role = rme_pkg::ROLE_MASTER;
                        w_adv  = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // advertisement: seed or bump the counter, fill the send fields
        if (w_adv && i_cfg.has_addresses) begin
            n_replay   = n_unseeded ? r_in.random_value : n_replay + 64'd1;
            n_unseeded = 1'b0;
            n_out.send_advert    = 1'b1;
            n_out.advert_counter = n_replay;
            n_out.advert_base    = i_cfg.base_interval;
            n_out.advert_skew    = i_cfg.skew;
        end

        // timer reloads
        if (w_adv) begin
            n_countdown = w_master_load;
            n_running   = 1'b1;
        end else if (w_ld_own) begin
            n_countdown = w_own_down;
            n_running   = 1'b1;
        end else if (w_ld_rx) begin
            n_countdown = w_rx_down;
            n_running   = 1'b1;
        end

        n_out.current_state = n_role;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role      <= rme_pkg::ROLE_INIT;
            r_countdown <= '0;
            r_running   <= 1'b0;
            r_replay    <= '0;
            r_unseeded  <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_role      <= n_role;
                r_countdown <= n_countdown;
                r_running   <= n_running;
                r_replay    <= n_replay;
                r_unseeded  <= n_unseeded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= n_out;
        end
    end
endmodule

>>> hw/rtl/redundancy_master_election.sv
// top level of the redundancy group master/backup election block
//
//  channel   kind           direction  word
//  i_in      valid/ready    in         rme_pkg::t_in_word  (tick, advert, user request)
//  o_out     valid/ready    out        rme_pkg::t_out_word (status, role, advert request)
//  apb       psel/penable   in         register writes and reads, 32-bit data
//
// one word is taken every cycle unless the output stalls; its result passes the input
// register, which loads at the accepting edge, and then the result register. the role,
// timer and counter registers load together with the result register.
// a stalled output holds its word; a new word is still taken while the input stage is free.
// synchronous reset puts the registers at their reset values, the role in init,
// the timer stopped and the counter unseeded.
module redundancy_master_election #(
    parameter int TICKS_PER_SECOND = rme_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rme_stream_if.sink                  i_in,
    rme_stream_if.source                o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]  paddr,
    input  logic [rme_pkg::DATA_W-1:0]  pwdata,
    output logic [rme_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    rme_pkg::t_cfg w_cfg;

    // configuration registers
    rme_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // election core
    rme_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule
